// File: rtl/core/cttu_pkg.sv
package cttu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_COMMA     = 8'h2c;
    localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CH_UPPER_LO  = 8'h41;
    localparam logic [7:0] CH_UPPER_HI  = 8'h5a;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDERLINE = 8'h5f;
    localparam logic [7:0] CH_LOWER_LO  = 8'h61;
    localparam logic [7:0] CH_LOWER_HI  = 8'h7a;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7e;

    localparam logic [1:0] TAG_NORMAL  = 2'd0;
    localparam logic [1:0] TAG_LITERAL = 2'd1;

    typedef enum logic [3:0] {
        KIND_END       = 4'd0,
        KIND_SYMBOL    = 4'd1,
        KIND_NUMBER    = 4'd2,
        KIND_COMMAND   = 4'd3,
        KIND_IDENT     = 4'd4,
        KIND_COMMA     = 4'd5,
        KIND_LPAREN    = 4'd6,
        KIND_RPAREN    = 4'd7,
        KIND_BACKSLASH = 4'd8,
        KIND_NEWLINE   = 4'd9,
        KIND_UNKNOWN   = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        RUN_NONE   = 3'b001,
        RUN_NUMBER = 3'b010,
        RUN_IDENT  = 3'b100
    } t_run;

    typedef struct packed {
        logic [7:0] char_value;
        logic [1:0] char_tag;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        t_kind      token_kind;
        logic       token_first;
        logic       token_last;
        logic [1:0] token_tag;
    } t_out_item;

    typedef struct packed {
        t_out_item res0;
        t_out_item res1;
        logic      two;
    } t_bundle;

endpackage

// File: rtl/core/command_text_tokenizer_unit.sv
// a punctuation or symbol beat is in the queue in the cycle after its character is taken
// digits, letters and underline are held until the next character or end of stream
// one character per cycle while full is low; results leave at one beat per cycle while pop is high and not empty;
// a character yields up to two beats, so full rises when the result queue backs up
// reset: synchronous active-low i_rst_n empties the queue and drops any held character
module command_text_tokenizer_unit #(
    parameter int QUEUE_DEPTH = cttu_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  cttu_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output cttu_pkg::t_out_item o_out_item
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    cttu_pkg::t_bundle q_wr_bundle;
    cttu_pkg::t_bundle q_head;

    assign full = q_full;

    cttu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_bundle (q_wr_bundle)
    );

    cttu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_wr_bundle),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_empty  (q_empty)
    );

    cttu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

// File: rtl/core/cttu_front.sv
module cttu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cttu_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output cttu_pkg::t_bundle  o_q_bundle
);

    logic           r_held_valid;
    logic [7:0]     r_held_char;
    logic           r_held_first;
    cttu_pkg::t_run r_run_mode;
    logic [1:0]     r_run_tag;
    logic           r_start_letter;

    logic           n_held_valid;
    logic [7:0]     n_held_char;
    logic           n_held_first;
    cttu_pkg::t_run n_run_mode;
    logic [1:0]     n_run_tag;
    logic           n_start_letter;

    logic                accept;
    logic [7:0]          c;
    logic                is_dig;
    logic                is_let;
    logic                is_idc;
    logic                held_emit;
    logic                held_last;
    logic                new_emit;
    cttu_pkg::t_kind     held_kind;
    cttu_pkg::t_out_item held_res;
    cttu_pkg::t_out_item new_res;

    assign accept = i_push && !i_q_full;
    assign c      = i_item.char_value;
    assign is_dig = (c >= cttu_pkg::CH_DIGIT_LO) && (c <= cttu_pkg::CH_DIGIT_HI);
    assign is_let = ((c >= cttu_pkg::CH_UPPER_LO) && (c <= cttu_pkg::CH_UPPER_HI))
                 || ((c >= cttu_pkg::CH_LOWER_LO) && (c <= cttu_pkg::CH_LOWER_HI));
    assign is_idc = is_dig || is_let || (c == cttu_pkg::CH_UNDERLINE);

    always_comb begin
        n_held_valid   = r_held_valid;
        n_held_char    = r_held_char;
        n_held_first   = r_held_first;
        n_run_mode     = r_run_mode;
        n_run_tag      = r_run_tag;
        n_start_letter = r_start_letter;
        held_emit      = r_held_valid;
        held_kind      = cttu_pkg::KIND_IDENT;
        held_last      = 1'b1;
        new_emit       = 1'b0;
        new_res        = '0;

        // decide the held character's kind from the incoming byte
        if (r_run_mode == cttu_pkg::RUN_NUMBER) begin
            held_kind = cttu_pkg::KIND_NUMBER;
            held_last = !is_dig;
        end else if (r_held_first && r_start_letter) begin
            if (!is_dig && is_idc) begin
                held_kind = cttu_pkg::KIND_IDENT;
                held_last = 1'b0;
            end else begin
                held_kind = cttu_pkg::KIND_COMMAND;
                held_last = 1'b1;
            end
        end else begin
            held_kind = cttu_pkg::KIND_IDENT;
            held_last = !is_idc;
        end

        if (i_item.stream_end) begin
            if (r_held_first && r_start_letter && r_run_mode != cttu_pkg::RUN_NUMBER) begin
                held_kind = cttu_pkg::KIND_COMMAND;
            end
            held_last                = 1'b1;
            new_emit                 = 1'b1;
            new_res.out_char         = '0;
            new_res.token_kind       = cttu_pkg::KIND_END;
            new_res.token_first      = 1'b1;
            new_res.token_last       = 1'b1;
            new_res.token_tag        = '0;
            n_held_valid             = 1'b0;
            n_held_first             = 1'b0;
            n_run_mode               = cttu_pkg::RUN_NONE;
            n_run_tag                = '0;
            n_start_letter           = 1'b0;
        end else if (r_held_valid && !held_last) begin
            n_held_char    = c;
            n_held_first   = 1'b0;
            n_start_letter = 1'b0;
        end else begin
            n_held_valid        = 1'b0;
            n_held_first        = 1'b0;
            n_run_mode          = cttu_pkg::RUN_NONE;
            n_run_tag           = '0;
            n_start_letter      = 1'b0;
            new_res.out_char    = c;
            new_res.token_first = 1'b1;
            new_res.token_last  = 1'b1;
            new_res.token_tag   = i_item.char_tag;
            new_res.token_kind  = cttu_pkg::KIND_SYMBOL;
            if (i_item.char_tag == cttu_pkg::TAG_NORMAL && (c == cttu_pkg::CH_SPACE
                    || c == cttu_pkg::CH_TAB || c == cttu_pkg::CH_CR)) begin
                new_emit = 1'b0;
            end else if (i_item.char_tag == cttu_pkg::TAG_LITERAL && !is_idc) begin
                new_emit = 1'b1;
            end else if (is_idc) begin
                n_held_valid   = 1'b1;
                n_held_char    = c;
                n_held_first   = 1'b1;
                n_run_mode     = is_dig ? cttu_pkg::RUN_NUMBER : cttu_pkg::RUN_IDENT;
                n_run_tag      = i_item.char_tag;
                n_start_letter = is_let;
            end else begin
                new_emit = 1'b1;
                case (c) inside
                    cttu_pkg::CH_COMMA:     new_res.token_kind = cttu_pkg::KIND_COMMA;
                    cttu_pkg::CH_LPAREN:    new_res.token_kind = cttu_pkg::KIND_LPAREN;
                    cttu_pkg::CH_RPAREN:    new_res.token_kind = cttu_pkg::KIND_RPAREN;
                    cttu_pkg::CH_BACKSLASH: new_res.token_kind = cttu_pkg::KIND_BACKSLASH;
                    cttu_pkg::CH_NEWLINE:   new_res.token_kind = cttu_pkg::KIND_NEWLINE;
                    [cttu_pkg::CH_PRINT_LO:cttu_pkg::CH_PRINT_HI]: begin
                        new_res.token_kind = cttu_pkg::KIND_SYMBOL;
                    end
                    default:                new_res.token_kind = cttu_pkg::KIND_UNKNOWN;
                endcase
            end
        end
    end

    always_comb begin
        held_res.out_char    = r_held_char;
        held_res.token_kind  = held_kind;
        held_res.token_first = r_held_first;
        held_res.token_last  = held_last;
        held_res.token_tag   = r_run_tag;
    end

    assign o_q_push        = accept && (held_emit || new_emit);
    assign o_q_bundle.res0 = held_emit ? held_res : new_res;
    assign o_q_bundle.res1 = new_res;
    assign o_q_bundle.two  = held_emit && new_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid   <= 1'b0;
            r_held_first   <= 1'b0;
            r_run_mode     <= cttu_pkg::RUN_NONE;
            r_run_tag      <= '0;
            r_start_letter <= 1'b0;
        end else if (accept) begin
            r_held_valid   <= n_held_valid;
            r_held_first   <= n_held_first;
            r_run_mode     <= n_run_mode;
            r_run_tag      <= n_run_tag;
            r_start_letter <= n_start_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held_char <= n_held_char;
        end
    end

`ifndef SYNTHESIS
    a_end_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.stream_end) |=> !r_held_valid)
        else $error("held character survives end of stream");

    a_held_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_run_mode != cttu_pkg::RUN_NONE))
        else $error("held character without a run");
`endif

endmodule

// File: rtl/core/cttu_queue.sv
module cttu_queue #(
    parameter int DEPTH = cttu_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cttu_pkg::t_bundle i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output cttu_pkg::t_bundle o_head,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cttu_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("bundle pushed into a full queue");
`endif

endmodule

// File: rtl/core/cttu_back.sv
module cttu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cttu_pkg::t_bundle   i_head,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output cttu_pkg::t_out_item o_item
);

    logic r_idx;
    logic take;

    assign o_empty = i_q_empty;
    assign o_item  = r_idx ? i_head.res1 : i_head.res0;
    assign take    = i_pop && !i_q_empty;
    assign o_q_pop = take && (r_idx || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 1'b0;
        end else if (take) begin
            r_idx <= !r_idx && i_head.two;
        end
    end

`ifndef SYNTHESIS
    a_second_beat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx |-> (!i_q_empty && i_head.two))
        else $error("second beat selected without a two-result bundle");
`endif

endmodule
